FILE: rtl/jvb_pkg.sv
`default_nettype none

package jvb_pkg;

   // Field widths
   localparam int PW  = 16;            // control period, unsigned Q0.16
   localparam int AW  = 31;            // acceleration and speed limits
   localparam int YW  = 32;            // distance to a position limit
   localparam int JW  = 32;            // braking step count
   localparam int BW  = 32;            // clamped braking bound

   // Derived widths
   localparam int APW       = PW + AW;        // period * accel
   localparam int KW        = 2 * PW + AW;    // period^2 * accel
   localparam int LIM_SHIFT = 33;             // distance scale of the step limit
   localparam int QW        = YW + LIM_SHIFT; // step limit quotient
   localparam int SQW       = 2 * JW;         // j*(j+1)
   localparam int TW        = YW + PW;        // velocity term divider width
   localparam int T2_SHIFT  = 17;
   localparam int T2W       = APW + JW - T2_SHIFT;
   localparam int VW        = 63;             // internal braking velocity

   // Constants
   localparam logic [VW-1:0] VEL_CAP    = VW'(1) << 62;
   localparam logic [BW-1:0] BND_CAP    = BW'(1) << 31;
   localparam logic [PW-1:0] PERIOD_RST = PW'(655);

endpackage

`default_nettype wire

FILE: rtl/joint_velocity_bound_calc_top.sv
`default_nettype none

// Joint velocity bounds: one joint word in, one bound word out, one word per clock
// sustained. Between an accepted request and rsp_tvalid each word passes the two
// braking-bound evaluations run back to back, each made of a 65-stage step
// limit divider, a 32-stage step count search and a 48-stage velocity divider. The
// upper and lower position limits are evaluated side by side. A stalled rsp channel
// holds the pipeline after one extra word lands in a skid register; req_tready
// drops only then. Period writes on the csr channel are taken at any time but must
// happen only with the pipeline empty; a zero period acts as one.

module joint_velocity_bound_calc_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // pos[31:0], vel[63:32], pos_min[95:64], pos_max[127:96],
   // speed_limit[158:128], accel_limit[189:159], zero[191:190]
   input  wire logic [191:0] req_tdata,
   input  wire logic         req_tlast,   // final_joint
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // vel_low[31:0], vel_high[63:32]
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tuser,   // collapsed
   output logic              rsp_tlast,   // final_out
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [15:0]  csr_data,
   input  wire logic         csr_valid,
   output logic              csr_ready
);

   localparam int PW  = jvb_pkg::PW;
   localparam int AW  = jvb_pkg::AW;
   localparam int YW  = jvb_pkg::YW;
   localparam int BW  = jvb_pkg::BW;
   localparam int APW = jvb_pkg::APW;
   localparam int XW  = 35;
   localparam int UPL = AW + AW + 1;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic        col;
      logic        last;
   } result_type;

   logic en;

   // Period register and its square
   logic [PW-1:0]   period_ff;
   logic [2*PW-1:0] period_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= jvb_pkg::PERIOD_RST;
      end else if (csr_valid) begin
         period_ff <= (csr_data == '0) ? PW'(1) : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      period_sq_ff <= (2 * PW)'(period_ff) * (2 * PW)'(period_ff);
   end

   // Input stage
   logic          s0_vld_ff;
   logic [31:0]   pos_ff;
   logic [31:0]   vel0_ff;
   logic [31:0]   pmin_ff;
   logic [31:0]   pmax_ff;
   logic [AW-1:0] spd0_ff;
   logic [AW-1:0] acc0_ff;
   logic          last0_ff;

   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff   <= req_tdata[31:0];
         vel0_ff  <= req_tdata[63:32];
         pmin_ff  <= req_tdata[95:64];
         pmax_ff  <= req_tdata[127:96];
         spd0_ff  <= req_tdata[158:128];
         acc0_ff  <= (req_tdata[189:159] == '0) ? AW'(1) : req_tdata[189:159];
         last0_ff <= req_tlast;
      end
   end

   // Distances to both limits and the reachable velocity step
   logic [APW-1:0] pa;
   logic           s1_vld_ff;
   logic [YW:0]    dist_hi_ff;
   logic [YW:0]    dist_lo_ff;
   logic [31:0]    vel1_ff;
   logic [AW-1:0]  spd1_ff;
   logic [AW-1:0]  acc1_ff;
   logic [AW-1:0]  du1_ff;
   logic           last1_ff;

   assign pa = APW'(period_ff) * APW'(acc0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_hi_ff <= {pmax_ff[31], pmax_ff} - {pos_ff[31], pos_ff};
         dist_lo_ff <= {pos_ff[31], pos_ff} - {pmin_ff[31], pmin_ff};
         vel1_ff    <= vel0_ff;
         spd1_ff    <= spd0_ff;
         acc1_ff    <= acc0_ff;
         du1_ff     <= pa[APW-1:PW];
         last1_ff   <= last0_ff;
      end
   end

   // Braking bounds toward the upper and lower limits
   logic           up_vld;
   logic [BW-1:0]  up_bound;
   logic [UPL-1:0] up_pl;
   logic           dn_vld;
   logic [BW-1:0]  dn_bound;
   logic [31:0]    dn_pl;

   jvb_bound #(.PLW(UPL)) u_upper (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .period    (period_ff),
      .period_sq (period_sq_ff),
      .in_vld    (s1_vld_ff),
      .in_diff   (dist_hi_ff),
      .in_accel  (acc1_ff),
      .in_pl     ({spd1_ff, du1_ff, last1_ff}),
      .out_vld   (up_vld),
      .out_bound (up_bound),
      .out_pl    (up_pl)
   );

   jvb_bound #(.PLW(32)) u_lower (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .period    (period_ff),
      .period_sq (period_sq_ff),
      .in_vld    (s1_vld_ff),
      .in_diff   (dist_lo_ff),
      .in_accel  (acc1_ff),
      .in_pl     (vel1_ff),
      .out_vld   (dn_vld),
      .out_bound (dn_bound),
      .out_pl    (dn_pl)
   );

   // Combine the three sources on each side
   logic signed [XW-1:0] v_x;
   logic signed [XW-1:0] du_x;
   logic signed [XW-1:0] s_x;
   logic signed [XW-1:0] bh_x;
   logic signed [XW-1:0] bl_x;
   logic signed [XW-1:0] up_x;
   logic signed [XW-1:0] dn_x;
   logic signed [XW-1:0] hi_x;
   logic signed [XW-1:0] lo_x;

   assign v_x  = {{(XW - 32){dn_pl[31]}}, dn_pl};
   assign s_x  = XW'(up_pl[UPL-1 -: AW]);
   assign du_x = XW'(up_pl[AW:1]);
   assign bh_x = XW'(up_bound);
   assign bl_x = XW'(dn_bound);
   assign up_x = v_x + du_x;
   assign dn_x = v_x - du_x;

   always_comb begin
      hi_x = up_x;
      if (s_x < hi_x) begin
         hi_x = s_x;
      end
      if (bh_x < hi_x) begin
         hi_x = bh_x;
      end
      lo_x = dn_x;
      if (-s_x > lo_x) begin
         lo_x = -s_x;
      end
      if (-bl_x > lo_x) begin
         lo_x = -bl_x;
      end
   end

   // Both results already lie within the signed 32-bit range
   logic        f1_vld_ff;
   logic [31:0] hi_ff;
   logic [31:0] lo_ff;
   logic        last2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= up_vld && dn_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff    <= hi_x[31:0];
         lo_ff    <= lo_x[31:0];
         last2_ff <= up_pl[0];
      end
   end

   // Collapse crossed bounds onto the upper one
   result_type res;
   logic       crossed;

   assign crossed = $signed(hi_ff) < $signed(lo_ff);

   always_comb begin
      res.hi   = hi_ff;
      res.lo   = crossed ? hi_ff : lo_ff;
      res.col  = crossed;
      res.last = last2_ff;
   end

   // Output register with skid
   logic       out_vld_ff;
   logic       skid_vld_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       take;

   assign en   = !skid_vld_ff;
   assign take = f1_vld_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= take;
         end
      end else if (take) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_ff <= skid_vld_ff ? skid_ff : res;
      end else if (take) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.hi, out_ff.lo};
   assign rsp_tuser  = out_ff.col;
   assign rsp_tlast  = out_ff.last;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a word while the output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_tready))
      else $error("skid filled without a stalled output");

   a_collapse_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == rsp_tdata[63:32])
      else $error("collapsed word with unequal bounds");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[31:0]) <= $signed(rsp_tdata[63:32]))
      else $error("lower bound above upper bound");

endmodule

`default_nettype wire

FILE: rtl/jvb_div.sv
`default_nettype none

module jvb_div #(
   parameter int NW  = 48,
   parameter int DW  = 48,
   parameter int PLW = 1
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_vld,
   input  wire logic [NW-1:0]  in_num,
   input  wire logic [DW-1:0]  in_den,
   input  wire logic [PLW-1:0] in_pl,
   output logic                out_vld,
   output logic [NW-1:0]       out_quo,
   output logic [PLW-1:0]      out_pl
);

   logic           vld_ff [NW];
   logic [DW-1:0]  rem_ff [NW];
   logic [NW-1:0]  quo_ff [NW];
   logic [NW-1:0]  num_ff [NW];
   logic [DW-1:0]  den_ff [NW];
   logic [PLW-1:0] pl_ff  [NW];

   // One quotient bit per stage, restoring form
   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic           pv;
      logic [DW-1:0]  pr;
      logic [DW-1:0]  pd;
      logic [NW-1:0]  pq;
      logic [NW-1:0]  pn;
      logic [PLW-1:0] ppl;
      logic [DW:0]    trial;
      logic [DW:0]    diff;
      logic           ge;
      logic [DW-1:0]  rem_in;

      if (i == 0) begin : g_first
         assign pv  = in_vld;
         assign pr  = '0;
         assign pd  = in_den;
         assign pq  = '0;
         assign pn  = in_num;
         assign ppl = in_pl;
      end else begin : g_next
         assign pv  = vld_ff[i-1];
         assign pr  = rem_ff[i-1];
         assign pd  = den_ff[i-1];
         assign pq  = quo_ff[i-1];
         assign pn  = num_ff[i-1];
         assign ppl = pl_ff[i-1];
      end

      assign trial  = {pr, pn[NW-1]};
      assign diff   = trial - {1'b0, pd};
      assign ge     = trial >= {1'b0, pd};
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= {pq[NW-2:0], ge};
            num_ff[i] <= {pn[NW-2:0], 1'b0};
            den_ff[i] <= pd;
            pl_ff[i]  <= ppl;
         end
      end
   end

   assign out_vld = vld_ff[NW-1];
   assign out_quo = quo_ff[NW-1];
   assign out_pl  = pl_ff[NW-1];

endmodule

`default_nettype wire

FILE: rtl/jvb_isqrt.sv
`default_nettype none

module jvb_isqrt #(
   parameter int PLW = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_vld,
   input  wire logic [jvb_pkg::QW-1:0] in_lim,
   input  wire logic [PLW-1:0]         in_pl,
   output logic                        out_vld,
   output logic [jvb_pkg::JW-1:0]      out_root,
   output logic [PLW-1:0]              out_pl
);

   localparam int JW  = jvb_pkg::JW;
   localparam int QW  = jvb_pkg::QW;
   localparam int SQW = jvb_pkg::SQW;

   logic           vld_ff  [JW];
   logic [QW-1:0]  lim_ff  [JW];
   logic [JW-1:0]  root_ff [JW];
   logic [SQW-1:0] sq_ff   [JW];
   logic [PLW-1:0] pl_ff   [JW];

   // Largest j with j*(j+1) <= limit, one bit per stage from the top;
   // j*(j+1) is kept alongside and updated by shifts and adds
   for (genvar i = 0; i < JW; i++) begin : g_stage
      localparam int B = JW - 1 - i;
      logic           pv;
      logic [QW-1:0]  plim;
      logic [JW-1:0]  proot;
      logic [SQW-1:0] psq;
      logic [PLW-1:0] ppl;
      logic [QW-1:0]  cand;
      logic           fits;
      logic [JW-1:0]  root_in;
      logic [SQW-1:0] sq_in;

      if (i == 0) begin : g_first
         assign pv    = in_vld;
         assign plim  = in_lim;
         assign proot = '0;
         assign psq   = '0;
         assign ppl   = in_pl;
      end else begin : g_next
         assign pv    = vld_ff[i-1];
         assign plim  = lim_ff[i-1];
         assign proot = root_ff[i-1];
         assign psq   = sq_ff[i-1];
         assign ppl   = pl_ff[i-1];
      end

      assign cand    = QW'(psq) + (QW'(proot) << (B + 1)) + (QW'(1) << B)
                       + (QW'(1) << (2 * B));
      assign fits    = cand <= plim;
      assign root_in = fits ? (proot | (JW'(1) << B)) : proot;
      assign sq_in   = fits ? cand[SQW-1:0] : psq;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lim_ff[i]  <= plim;
            root_ff[i] <= root_in;
            sq_ff[i]   <= sq_in;
            pl_ff[i]   <= ppl;
         end
      end
   end

   assign out_vld  = vld_ff[JW-1];
   assign out_root = root_ff[JW-1];
   assign out_pl   = pl_ff[JW-1];

endmodule

`default_nettype wire

FILE: rtl/jvb_brake.sv
`default_nettype none

module jvb_brake #(
   parameter int PLW = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic [jvb_pkg::PW-1:0]   period,
   input  wire logic [2*jvb_pkg::PW-1:0] period_sq,
   input  wire logic                     in_vld,
   input  wire logic [jvb_pkg::YW-1:0]   in_dist,
   input  wire logic [jvb_pkg::AW-1:0]   in_accel,
   input  wire logic [PLW-1:0]           in_pl,
   output logic                          out_vld,
   output logic [jvb_pkg::VW-1:0]        out_vel,
   output logic [PLW-1:0]                out_pl
);

   localparam int PW   = jvb_pkg::PW;
   localparam int YW   = jvb_pkg::YW;
   localparam int JW   = jvb_pkg::JW;
   localparam int APW  = jvb_pkg::APW;
   localparam int KW   = jvb_pkg::KW;
   localparam int QW   = jvb_pkg::QW;
   localparam int TW   = jvb_pkg::TW;
   localparam int T2W  = jvb_pkg::T2W;
   localparam int VW   = jvb_pkg::VW;
   localparam int HJ   = JW / 2;
   localparam int PRW  = APW + HJ;
   localparam int MW   = PW + JW + 1;
   localparam int D1PL = YW + APW + PLW;
   localparam int D2PL = T2W + PLW;

   // Front stage: period^2 * accel and period * accel
   logic            b0_vld_ff;
   logic [KW-1:0]   k_ff;
   logic [APW-1:0]  ap_ff;
   logic [YW-1:0]   y0_ff;
   logic [PLW-1:0]  pl0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff <= 1'b0;
      end else if (en) begin
         b0_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff   <= KW'(period_sq) * KW'(in_accel);
         ap_ff  <= APW'(period) * APW'(in_accel);
         y0_ff  <= in_dist;
         pl0_ff <= in_pl;
      end
   end

   // Step limit: floor(y * 2^33 / k)
   logic            d1_vld;
   logic [QW-1:0]   d1_quo;
   logic [D1PL-1:0] d1_pl;

   jvb_div #(.NW(QW), .DW(KW), .PLW(D1PL)) u_lim_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (b0_vld_ff),
      .in_num  ({y0_ff, {jvb_pkg::LIM_SHIFT{1'b0}}}),
      .in_den  (k_ff),
      .in_pl   ({y0_ff, ap_ff, pl0_ff}),
      .out_vld (d1_vld),
      .out_quo (d1_quo),
      .out_pl  (d1_pl)
   );

   // Braking step count j
   logic            sq_vld;
   logic [JW-1:0]   sq_root;
   logic [D1PL-1:0] sq_pl;

   jvb_isqrt #(.PLW(D1PL)) u_steps (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (d1_vld),
      .in_lim   (d1_quo),
      .in_pl    (d1_pl),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_pl   (sq_pl)
   );

   // Divisor period*(j+1) and halves of ap*j
   logic [JW:0]     jp1;
   logic [MW-1:0]   m_full;
   logic            b1_vld_ff;
   logic [TW-1:0]   m1_ff;
   logic [PRW-1:0]  prod_hi_ff;
   logic [PRW-1:0]  prod_lo_ff;
   logic [YW-1:0]   y1_ff;
   logic [PLW-1:0]  pl1_ff;

   assign jp1    = (JW + 1)'(sq_root) + (JW + 1)'(1);
   assign m_full = MW'(period) * MW'(jp1);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
      end else if (en) begin
         b1_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff      <= m_full[TW-1:0];
         prod_hi_ff <= PRW'(sq_pl[PLW+APW-1 -: APW]) * PRW'(sq_root[JW-1:HJ]);
         prod_lo_ff <= PRW'(sq_pl[PLW+APW-1 -: APW]) * PRW'(sq_root[HJ-1:0]);
         y1_ff      <= sq_pl[D1PL-1 -: YW];
         pl1_ff     <= sq_pl[PLW-1:0];
      end
   end

   // Combine halves into floor(a*p*j / 2^17)
   logic [APW+JW-1:0] tsum;
   logic              b2_vld_ff;
   logic [T2W-1:0]    t2_ff;
   logic [TW-1:0]     m2_ff;
   logic [YW-1:0]     y2_ff;
   logic [PLW-1:0]    pl2_ff;

   assign tsum = {prod_hi_ff, {HJ{1'b0}}} + (APW + JW)'(prod_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_vld_ff <= 1'b0;
      end else if (en) begin
         b2_vld_ff <= b1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff  <= tsum[APW+JW-1:jvb_pkg::T2_SHIFT];
         m2_ff  <= m1_ff;
         y2_ff  <= y1_ff;
         pl2_ff <= pl1_ff;
      end
   end

   // First velocity term: floor(y * 2^16 / (period*(j+1)))
   logic            d2_vld;
   logic [TW-1:0]   d2_quo;
   logic [D2PL-1:0] d2_pl;

   jvb_div #(.NW(TW), .DW(TW), .PLW(D2PL)) u_vel_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (b2_vld_ff),
      .in_num  ({y2_ff, {PW{1'b0}}}),
      .in_den  (m2_ff),
      .in_pl   ({t2_ff, pl2_ff}),
      .out_vld (d2_vld),
      .out_quo (d2_quo),
      .out_pl  (d2_pl)
   );

   // Sum both terms and clamp
   logic [VW-1:0]  vsum;
   logic           b3_vld_ff;
   logic [VW-1:0]  vel_ff;
   logic [PLW-1:0] pl3_ff;

   assign vsum = VW'(d2_quo) + VW'(d2_pl[D2PL-1 -: T2W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_vld_ff <= 1'b0;
      end else if (en) begin
         b3_vld_ff <= d2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vel_ff <= (vsum > jvb_pkg::VEL_CAP) ? jvb_pkg::VEL_CAP : vsum;
         pl3_ff <= d2_pl[PLW-1:0];
      end
   end

   assign out_vld = b3_vld_ff;
   assign out_vel = vel_ff;
   assign out_pl  = pl3_ff;

endmodule

`default_nettype wire

FILE: rtl/jvb_bound.sv
`default_nettype none

module jvb_bound #(
   parameter int PLW = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic [jvb_pkg::PW-1:0]   period,
   input  wire logic [2*jvb_pkg::PW-1:0] period_sq,
   input  wire logic                     in_vld,
   input  wire logic [jvb_pkg::YW:0]     in_diff,
   input  wire logic [jvb_pkg::AW-1:0]   in_accel,
   input  wire logic [PLW-1:0]           in_pl,
   output logic                          out_vld,
   output logic [jvb_pkg::BW-1:0]        out_bound,
   output logic [PLW-1:0]                out_pl
);

   localparam int PW   = jvb_pkg::PW;
   localparam int YW   = jvb_pkg::YW;
   localparam int AW   = jvb_pkg::AW;
   localparam int TW   = jvb_pkg::TW;
   localparam int VW   = jvb_pkg::VW;
   localparam int BW   = jvb_pkg::BW;
   localparam int P1W  = 1 + YW + AW + PLW;
   localparam int P2W  = 1 + PLW;

   // Distance is usable only when strictly positive
   logic in_pos;
   assign in_pos = !in_diff[YW] && (in_diff[YW-1:0] != '0);

   logic           k1_vld;
   logic [VW-1:0]  k1_vel;
   logic [P1W-1:0] k1_pl;

   jvb_brake #(.PLW(P1W)) u_first (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .period    (period),
      .period_sq (period_sq),
      .in_vld    (in_vld),
      .in_dist   (in_diff[YW-1:0]),
      .in_accel  (in_accel),
      .in_pl     ({in_pos, in_diff[YW-1:0], in_accel, in_pl}),
      .out_vld   (k1_vld),
      .out_vel   (k1_vel),
      .out_pl    (k1_pl)
   );

   // Distance covered in one period at the first bound
   logic [PW+TW-1:0] dprod;
   logic             s1_vld_ff;
   logic             big_ff;
   logic [TW-1:0]    d_ff;
   logic [P1W-1:0]   pl1_ff;

   assign dprod = (PW + TW)'(period) * (PW + TW)'(k1_vel[TW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= k1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big_ff <= k1_vel[VW-1:TW] != '0;
         d_ff   <= dprod[PW+TW-1:PW];
         pl1_ff <= k1_pl;
      end
   end

   // Shorten the distance, or drop the bound when it is used up
   logic           pos1;
   logic [YW-1:0]  y1;
   logic           s2_vld_ff;
   logic           keep_ff;
   logic [YW-1:0]  y2_ff;
   logic [AW-1:0]  a2_ff;
   logic [PLW-1:0] pl2_ff;

   assign pos1 = pl1_ff[P1W-1];
   assign y1   = pl1_ff[P1W-2 -: YW];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         keep_ff <= pos1 && !big_ff && (d_ff < TW'(y1));
         y2_ff   <= y1 - d_ff[YW-1:0];
         a2_ff   <= pl1_ff[PLW+AW-1 -: AW];
         pl2_ff  <= pl1_ff[PLW-1:0];
      end
   end

   logic           k2_vld;
   logic [VW-1:0]  k2_vel;
   logic [P2W-1:0] k2_pl;

   jvb_brake #(.PLW(P2W)) u_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .period    (period),
      .period_sq (period_sq),
      .in_vld    (s2_vld_ff),
      .in_dist   (y2_ff),
      .in_accel  (a2_ff),
      .in_pl     ({keep_ff, pl2_ff}),
      .out_vld   (k2_vld),
      .out_vel   (k2_vel),
      .out_pl    (k2_pl)
   );

   // Clamp to just above any speed limit; zero when dropped
   logic           s3_vld_ff;
   logic [BW-1:0]  bound_ff;
   logic [PLW-1:0] pl3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= k2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (!k2_pl[P2W-1]) begin
            bound_ff <= '0;
         end else if (k2_vel > VW'(jvb_pkg::BND_CAP)) begin
            bound_ff <= jvb_pkg::BND_CAP;
         end else begin
            bound_ff <= k2_vel[BW-1:0];
         end
         pl3_ff <= k2_pl[PLW-1:0];
      end
   end

   assign out_vld   = s3_vld_ff;
   assign out_bound = bound_ff;
   assign out_pl    = pl3_ff;

endmodule

`default_nettype wire

FILE: sim/tb.sv
module tb;

   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] pmin;
      logic signed [31:0] pmax;
      logic [30:0]        speed;
      logic [30:0]        accel;
      logic               last;
   } joint_type;

   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic               col;
      logic               last;
   } bound_type;

   // Bound predictor plus the queue of bounds still owed by the block
   class bound_board;
      logic [15:0] period;
      bound_type   owed[$];
      int          errors;

      function new();
         period = jvb_pkg::PERIOD_RST;
         errors = 0;
      endfunction

      // Velocity that still allows stopping within distance y
      function automatic logic [127:0] stop_vel(logic [127:0] y, logic [127:0] p,
                                                logic [127:0] a);
         logic [127:0] k, lim, c, j, t1, t2, v;
         k   = p * p * a;
         lim = (y << 33) / k;
         if (lim > 128'hFFFF_FFFF_FFFF_FFFF) lim = 128'hFFFF_FFFF_FFFF_FFFF;
         j = 0;
         for (int b = 31; b >= 0; b--) begin
            c = j | (128'd1 << b);
            if (c * (c + 1) <= lim) j = c;
         end
         t1 = (y << 16) / (p * (j + 1));
         t2 = (a * p * j) >> 17;
         v  = t1 + t2;
         if (v > (128'd1 << 62)) v = 128'd1 << 62;
         return v;
      endfunction

      // Braking bound toward one position limit, two passes
      function automatic longint limit_vel(longint x, logic [127:0] p, logic [127:0] a);
         logic [127:0] y, v, d;
         if (x <= 0) return 0;
         y = 128'(x);
         v = stop_vel(y, p, a);
         d = (p * v) >> 16;
         if (d >= y) return 0;
         return longint'(stop_vel(y - d, p, a));
      endfunction

      function automatic logic signed [31:0] clip(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      // Work out the expected bounds of one accepted joint
      function void note_joint(joint_type jt);
         logic [127:0] p, a;
         longint du, hi, lo, ub, lb, s, q, v;
         bound_type r;
         p  = (period == 0) ? 128'd1 : 128'(period);
         a  = (jt.accel == 0) ? 128'd1 : 128'(jt.accel);
         du = longint'((p * a) >> 16);
         s  = longint'(jt.speed);
         q  = longint'(jt.pos);
         v  = longint'(jt.vel);
         ub = limit_vel(longint'(jt.pmax) - q, p, a);
         lb = -limit_vel(q - longint'(jt.pmin), p, a);
         hi = v + du;
         if (s < hi) hi = s;
         if (ub < hi) hi = ub;
         lo = v - du;
         if (-s > lo) lo = -s;
         if (lb > lo) lo = lb;
         r.col = 0;
         if (hi < lo) begin
            lo = hi;
            r.col = 1;
         end
         r.lo   = clip(lo);
         r.hi   = clip(hi);
         r.last = jt.last;
         owed.push_back(r);
      endfunction

      // Compare one returned word with the oldest expectation
      function void check_bound(bound_type got);
         bound_type e;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected bound word lo=%0d hi=%0d", got.lo, got.hi);
            return;
         end
         e = owed.pop_front();
         if (got.lo !== e.lo || got.hi !== e.hi || got.col !== e.col || got.last !== e.last)
         begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp lo=%0d hi=%0d col=%0b last=%0b, ",
                         "got lo=%0d hi=%0d col=%0b last=%0b"},
                        e.lo, e.hi, e.col, e.last, got.lo, got.hi, got.col, got.last);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic [191:0] req_tdata;
   logic         req_tlast;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  csr_data;
   logic         csr_valid;
   logic         csr_ready;

   bound_board board;
   int         send_idle;
   int         recv_idle;

   joint_velocity_bound_calc_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Hard stop
   initial begin
      #(8 * 600000);
      $display("FAIL joint_velocity_bound_calc_top");
      $finish;
   end

   // Sample bound words and stall the receiver at random
   always @(posedge clock) begin
      bound_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lo   = rsp_tdata[31:0];
         got.hi   = rsp_tdata[63:32];
         got.col  = rsp_tuser;
         got.last = rsp_tlast;
         board.check_bound(got);
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Idle at random, then send one joint word and hold it until accepted
   task automatic send_joint(joint_type jt);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {2'b00, jt.accel, jt.speed, jt.pmax, jt.pmin, jt.vel, jt.pos};
      req_tlast  <= jt.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_joint(jt);
   endtask

   // Drain the pipeline, then write the period
   task automatic set_period(logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (320) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.period = value;
   endtask

   function automatic logic signed [31:0] rnd_mag();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // Joints near or past their limits, plus some fully random words
   function automatic joint_type rnd_joint();
      joint_type jt;
      logic signed [31:0] span;
      jt.last  = ($urandom_range(0, 5) == 0);
      jt.speed = 31'($urandom >> $urandom_range(1, 20));
      jt.accel = 31'($urandom >> $urandom_range(1, 24));
      if ($urandom_range(0, 9) < 3) begin
         jt.pos  = $urandom;
         jt.vel  = $urandom;
         jt.pmin = $urandom;
         jt.pmax = $urandom;
         jt.speed = 31'($urandom);
         jt.accel = 31'($urandom);
      end else begin
         span    = rnd_mag() >>> 1;
         jt.pmin = $signed($urandom) >>> $urandom_range(1, 8);
         jt.pmax = jt.pmin + span;
         case ($urandom_range(0, 3))
            0: jt.pos = jt.pmin + (rnd_mag() >>> 2);
            1: jt.pos = jt.pmax - (rnd_mag() >>> 2);
            2: jt.pos = jt.pmin - (rnd_mag() >>> 4);
            default: jt.pos = jt.pmax + (rnd_mag() >>> 4);
         endcase
         jt.vel = ($urandom_range(0, 1) ? rnd_mag() : -rnd_mag()) >>> 1;
      end
      return jt;
   endfunction

   function automatic joint_type mk(logic signed [31:0] pos, logic signed [31:0] vel,
                                    logic signed [31:0] pmin, logic signed [31:0] pmax,
                                    logic [30:0] speed, logic [30:0] accel, logic last);
      joint_type jt;
      jt.pos = pos; jt.vel = vel; jt.pmin = pmin; jt.pmax = pmax;
      jt.speed = speed; jt.accel = accel; jt.last = last;
      return jt;
   endfunction

   initial begin
      logic [15:0] periods[5];
      int n;
      board      = new();
      send_idle  = 28;
      recv_idle  = 72;
      reset      = 1'b1;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_data   = '0;
      csr_valid  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, joints at and past limits, crossed bounds
      send_joint(mk(0, 0, -32'sd65536, 32'sd65536, 31'd65536, 31'd65536, 0));
      send_joint(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
      send_joint(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
      send_joint(mk(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1, 0));
      send_joint(mk(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 1, 1));
      send_joint(mk(100, 5000, 100, 100, 31'd10000, 31'd1000, 0));
      send_joint(mk(200, -5000, 300, 100, 31'd10000, 31'd1000, 0));
      send_joint(mk(0, 0, -1, 1, 0, 0, 1));
      send_joint(mk(0, 32'sh4000_0000, -32'sd65536, 32'sd65536, 31'h7FFF_FFFF, 1, 0));
      send_joint(mk(0, -32'sh4000_0000, -32'sd65536, 32'sd65536, 31'h7FFF_FFFF, 1, 0));
      send_joint(mk(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1, 0));
      send_joint(mk(0, 0, -1, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
      send_joint(mk(1000, 0, 0, 32'sh7FFF_FFFF, 31'd500, 31'd7, 1));
      send_joint(mk(-32'sd65536, 32'sd9999, -32'sd65537, 32'sd65536, 31'd1, 31'd65536, 0));

      // Periods: reset value, both extremes, zero, then random
      periods = '{16'd655, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 65534))};
      n = 0;
      for (int ph = 0; ph < 5; ph++) begin
         set_period(periods[ph]);
         for (int i = 0; i < 360; i++) begin
            if (n == 600) begin
               send_idle = 72;
               recv_idle = 28;
            end else if (n == 1200) begin
               send_idle = 0;
               recv_idle = 0;
            end
            send_joint(rnd_joint());
            n++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain and let the pipeline settle
      while (board.owed.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.errors == 0)
         $display("PASS joint_velocity_bound_calc_top");
      else
         $display("FAIL joint_velocity_bound_calc_top");
      $finish;
   end

endmodule

FILE: joint_velocity_bound_calc_top.f
rtl/jvb_pkg.sv
rtl/jvb_div.sv
rtl/jvb_isqrt.sv
rtl/jvb_brake.sv
rtl/jvb_bound.sv
rtl/joint_velocity_bound_calc_top.sv
sim/tb.sv
